// ===== src/ray_sphere_closest_hit_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray / sphere closest-hit unit
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_CLOSEST_HIT_UNIT_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_UNIT_MACROS_SVH

// Condition must hold at every edge out of reset.
`define RSCH_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RSCH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/rsch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared widths, request types and state encodings of the closest-hit unit.
// ----------------------------------------------------------------------------
package rsch_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int DIR_W      = 18;
    localparam int RAD_W      = 31;
    localparam int DIST_W     = 31;
    localparam int IDX_W      = 8;
    localparam int NRM_W      = 18;

    localparam int OFS_W      = COORD_W + 1;          // origin - centre
    localparam int MAG_W      = 32;                   // multiplier operand
    localparam int PROD_W     = 2 * MAG_W;
    localparam int DOT_W      = OFS_W + DIR_W + 1;    // sum of three products
    localparam int B_W        = DOT_W - FRAC_BITS;
    localparam int ROOT_W     = B_W + 2;
    localparam int OSQ_W      = PROD_W - FRAC_BITS + 2;
    localparam int BSQ_W      = PROD_W - FRAC_BITS;
    localparam int RSQ_W      = 2 * RAD_W - FRAC_BITS;
    localparam int DL_W       = PROD_W - FRAC_BITS;
    localparam int SQ_W       = PROD_W;
    localparam int SQRT_W     = SQ_W / 2;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    localparam int NPROD_W    = DIST_W + DIR_W;
    localparam int PT_W       = OFS_W + 2;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [Q_W-1:0] NRM_ONE = Q_W'(1) << FRAC_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W   = 3 * COORD_W + 3 * DIR_W + 3 * COORD_W + RAD_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = DIST_W + IDX_W + 3 * NRM_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          sphere_radius;
        logic                      last_sphere;
    } rsch_ray_t;

    // Classified sphere request handed from front to back.
    typedef struct packed {
        logic                    cand;
        logic [DIST_W-1:0]       t;
        logic signed [OFS_W-1:0] ofs_x;
        logic signed [OFS_W-1:0] ofs_y;
        logic signed [OFS_W-1:0] ofs_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [RAD_W-1:0]        radius;
        logic                    last;
    } rsch_item_t;

    typedef struct packed {
        logic                    hit;
        logic [DIST_W-1:0]       distance;
        logic [IDX_W-1:0]        sphere_index;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
    } rsch_result_t;

    typedef enum logic [2:0] {
        OP_DOT_X, OP_DOT_Y, OP_DOT_Z,
        OP_OSQ_X, OP_OSQ_Y, OP_OSQ_Z,
        OP_RSQ, OP_BSQ
    } fe_op_t;

    typedef enum logic [2:0] {
        FE_IDLE, FE_PREP, FE_MUL, FE_FIN, FE_DELTA, FE_SQRT, FE_ROOT, FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE, BE_EVAL, BE_MUL, BE_POINT, BE_SAT, BE_DIV, BE_NORM, BE_EMIT
    } be_state_t;

endpackage

// ===== src/ray_sphere_closest_hit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_unit
// Nearest ray / sphere hit over a stream of spheres, signed Q16.16.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | content
//  s_axis    | in        | tvalid / tready         | one sphere request per ray item
//  m_axis    | out       | tvalid / tready         | one result per ray (last sphere)
//  cfg       | in        | cfg_wr_en (no wait)     | far_limit, 31 bit
//
//  A sphere request occupies the front for the whole of its 32-step square
//  root loop, which dominates. A sphere that becomes the new nearest hit costs
//  the back three 17-step normal divides on one shared divider; others skip them.
//  A two-entry queue lets the front solve the next sphere while the back works.
//  Reset clears all control state; the far limit resets to 0x7FFFFFFF.
//  A held output result stalls the back; a full queue then stalls the front.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // center_x, center_y, center_z, sphere_radius, zero pad
    input  logic [rsch_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,   // last_sphere
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // distance, sphere_index, normal_x, normal_y, normal_z, zero pad
    output logic [rsch_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tuser,   // hit
    input  logic                                 cfg_wr_en,
    input  logic [rsch_pkg::DIST_W-1:0]          cfg_wr_data
);
    import rsch_pkg::*;

    localparam int DX = 3 * COORD_W;
    localparam int CX = DX + 3 * DIR_W;
    localparam int RX = CX + 3 * COORD_W;

    logic [DIST_W-1:0] far_limit_reg;
    rsch_ray_t         in_ray;
    rsch_item_t        q_item, q_rdata;
    logic              q_push, q_full, q_pop, q_valid;
    rsch_result_t      result;

    // Unpack the request; the first field sits in the lowest bits
    assign in_ray = '{origin_x: s_axis_tdata[COORD_W-1:0],
                      origin_y: s_axis_tdata[2*COORD_W-1:COORD_W],
                      origin_z: s_axis_tdata[3*COORD_W-1:2*COORD_W],
                      dir_x:    s_axis_tdata[DX+DIR_W-1:DX],
                      dir_y:    s_axis_tdata[DX+2*DIR_W-1:DX+DIR_W],
                      dir_z:    s_axis_tdata[DX+3*DIR_W-1:DX+2*DIR_W],
                      center_x: s_axis_tdata[CX+COORD_W-1:CX],
                      center_y: s_axis_tdata[CX+2*COORD_W-1:CX+COORD_W],
                      center_z: s_axis_tdata[CX+3*COORD_W-1:CX+2*COORD_W],
                      sphere_radius: s_axis_tdata[RX+RAD_W-1:RX],
                      last_sphere: s_axis_tlast};

    // Far limit takes effect when the next ray opens in the back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            far_limit_reg <= '1;
        else if (cfg_wr_en)
            far_limit_reg <= cfg_wr_data;
    end

    rsch_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_ray   (in_ray),
        .q_push   (q_push),
        .q_item   (q_item),
        .q_full   (q_full)
    );

    rsch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_rdata),
        .valid     (q_valid)
    );

    rsch_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .far_limit  (far_limit_reg),
        .q_valid    (q_valid),
        .q_item     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result; hit travels on tuser
    assign m_axis_tuser = result.hit;
    assign m_axis_tdata = {(OUT_TDATA_W - OUT_DATA_W)'(0),
                           result.normal_z, result.normal_y, result.normal_x,
                           result.sphere_index, result.distance};

    `include "ray_sphere_closest_hit_unit_macros.svh"

    `RSCH_ASSERT_IMPLY(a_queue_no_overflow, q_push, !q_full, "request pushed into full queue")
    `RSCH_ASSERT_IMPLY(a_queue_no_underflow, q_pop, q_valid, "request popped from empty queue")
    `RSCH_ASSERT_IMPLY(a_cand_nonzero, q_push && q_item.cand, q_item.t != '0, "hit with zero distance")
    `RSCH_ASSERT_IMPLY(a_miss_clean, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[OUT_TDATA_W-1:DIST_W] == '0, "miss result carries index or normal")

endmodule

// ===== src/rsch_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_front
// Accept a sphere request, solve the ray quadratic and classify the root.
// ----------------------------------------------------------------------------
module rsch_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsch_pkg::rsch_ray_t  in_ray,
    output logic                 q_push,
    output rsch_pkg::rsch_item_t q_item,
    input  logic                 q_full
);
    import rsch_pkg::*;

    fe_state_t               state_reg, state_next;
    logic signed [OFS_W-1:0] ofs_reg [3];
    logic [MAG_W-1:0]        om_reg [3];
    logic                    os_reg [3];
    logic signed [DIR_W-1:0] dir_reg [3];
    logic [DIR_W-1:0]        dm_reg [3];
    logic                    ds_reg [3];
    logic [RAD_W-1:0]        rad_reg;
    logic                    last_reg;

    fe_op_t                  op_reg, prod_op_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    prod_vld_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [B_W-1:0]   b_reg;
    logic [MAG_W-1:0]        ub_reg;
    logic [OSQ_W-1:0]        osq_reg;
    logic [BSQ_W-1:0]        bsq_reg;
    logic [RSQ_W-1:0]        rsq_reg;

    logic [SQ_W-1:0]         sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [SQRT_CNT_W-1:0]   sq_cnt_reg;
    logic                    delta_ok_reg;
    logic [DIST_W-1:0]       t_reg;
    logic                    cand_reg;

    logic [MAG_W-1:0]         mul_a, mul_b;
    logic                     dot_neg;
    logic signed [DOT_W-1:0]  dot_term;
    logic signed [B_W-1:0]    b_cur;
    logic [B_W-1:0]           bmag;
    logic [BSQ_W:0]           sq_sum;
    logic signed [OSQ_W:0]    diff;
    logic [DL_W-1:0]          dl;
    logic [SQ_W-1:0]          trial;
    logic signed [ROOT_W-1:0] nb, s_ext, near_r, far_r, t_sel;
    logic                     near_pos, far_pos;

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_DOT_X: begin mul_a = om_reg[0]; mul_b = MAG_W'(dm_reg[0]); end
            OP_DOT_Y: begin mul_a = om_reg[1]; mul_b = MAG_W'(dm_reg[1]); end
            OP_DOT_Z: begin mul_a = om_reg[2]; mul_b = MAG_W'(dm_reg[2]); end
            OP_OSQ_X: begin mul_a = om_reg[0]; mul_b = om_reg[0]; end
            OP_OSQ_Y: begin mul_a = om_reg[1]; mul_b = om_reg[1]; end
            OP_OSQ_Z: begin mul_a = om_reg[2]; mul_b = om_reg[2]; end
            OP_RSQ:   begin mul_a = MAG_W'(rad_reg); mul_b = MAG_W'(rad_reg); end
            OP_BSQ:   begin mul_a = ub_reg; mul_b = ub_reg; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        case (prod_op_reg)
            OP_DOT_X: dot_neg = os_reg[0] ^ ds_reg[0];
            OP_DOT_Y: dot_neg = os_reg[1] ^ ds_reg[1];
            OP_DOT_Z: dot_neg = os_reg[2] ^ ds_reg[2];
            default:  dot_neg = 1'b0;
        endcase
        dot_term = $signed({1'b0, prod_reg[DOT_W-2:0]});
        if (dot_neg)
            dot_term = -dot_term;
    end

    // floor(dot / 2^FRAC_BITS) is the upper slice; saturate |b| to 32 bits
    assign b_cur = dot_reg[DOT_W-1:FRAC_BITS];
    assign bmag  = b_cur[B_W-1] ? B_W'(-b_cur) : B_W'(b_cur);

    assign sq_sum = (BSQ_W+1)'(bsq_reg) + (BSQ_W+1)'(rsq_reg);
    assign diff   = $signed((OSQ_W+1)'(sq_sum)) - $signed((OSQ_W+1)'(osq_reg));
    assign dl     = (diff[OSQ_W-1:DL_W] != '0) ? '1 : diff[DL_W-1:0];
    assign trial  = sq_res_reg + sq_bit_reg;

    assign nb       = -ROOT_W'(b_reg);
    assign s_ext    = $signed(ROOT_W'(sq_res_reg[SQRT_W-1:0]));
    assign near_r   = nb - s_ext;
    assign far_r    = nb + s_ext;
    assign near_pos = !near_r[ROOT_W-1] && (near_r != '0);
    assign far_pos  = !far_r[ROOT_W-1] && (far_r != '0);
    assign t_sel    = near_pos ? near_r : (far_pos ? far_r : '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:  if (in_valid) state_next = FE_PREP;
            FE_PREP:  state_next = FE_MUL;
            FE_MUL:   if (op_reg == OP_BSQ) state_next = FE_FIN;
            FE_FIN:   state_next = FE_DELTA;
            FE_DELTA: state_next = FE_SQRT;
            FE_SQRT:  if (sq_cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) state_next = FE_ROOT;
            FE_ROOT:  state_next = FE_PUSH;
            FE_PUSH:  if (!q_full) state_next = FE_IDLE;
            default:  state_next = FE_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == FE_IDLE);
        q_push   = (state_reg == FE_PUSH) && !q_full;
    end

    assign q_item = '{cand: cand_reg, t: t_reg,
                      ofs_x: ofs_reg[0], ofs_y: ofs_reg[1], ofs_z: ofs_reg[2],
                      dir_x: dir_reg[0], dir_y: dir_reg[1], dir_z: dir_reg[2],
                      radius: rad_reg, last: last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FE_IDLE;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= (state_reg == FE_MUL);
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg    <= PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_op_reg <= op_reg;

        if (prod_vld_reg)
        begin
            case (prod_op_reg)
                OP_DOT_X, OP_DOT_Y, OP_DOT_Z: dot_reg <= dot_reg + dot_term;
                OP_OSQ_X, OP_OSQ_Y, OP_OSQ_Z:
                    osq_reg <= osq_reg + OSQ_W'(prod_reg[PROD_W-1:FRAC_BITS]);
                OP_RSQ:  rsq_reg <= prod_reg[2*RAD_W-1:FRAC_BITS];
                OP_BSQ:  bsq_reg <= prod_reg[PROD_W-1:FRAC_BITS];
                default: ;
            endcase
        end

        case (state_reg)
            FE_IDLE:
            begin
                ofs_reg[0] <= OFS_W'(in_ray.origin_x) - OFS_W'(in_ray.center_x);
                ofs_reg[1] <= OFS_W'(in_ray.origin_y) - OFS_W'(in_ray.center_y);
                ofs_reg[2] <= OFS_W'(in_ray.origin_z) - OFS_W'(in_ray.center_z);
                dir_reg[0] <= in_ray.dir_x;
                dir_reg[1] <= in_ray.dir_y;
                dir_reg[2] <= in_ray.dir_z;
                rad_reg    <= in_ray.sphere_radius;
                last_reg   <= in_ray.last_sphere;
            end
            FE_PREP:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    os_reg[k] <= ofs_reg[k][OFS_W-1];
                    om_reg[k] <= ofs_reg[k][OFS_W-1] ? MAG_W'(-ofs_reg[k])
                                                      : MAG_W'(ofs_reg[k]);
                    ds_reg[k] <= dir_reg[k][DIR_W-1];
                    dm_reg[k] <= dir_reg[k][DIR_W-1] ? DIR_W'(-dir_reg[k])
                                                      : DIR_W'(dir_reg[k]);
                end
                dot_reg <= '0;
                osq_reg <= '0;
                op_reg  <= OP_DOT_X;
            end
            FE_MUL:
            begin
                op_reg <= fe_op_t'(op_reg + 3'd1);
                // dot product is complete by the time r*r issues
                if (op_reg == OP_RSQ)
                begin
                    b_reg  <= b_cur;
                    ub_reg <= (bmag[B_W-1:MAG_W] != '0) ? '1 : bmag[MAG_W-1:0];
                end
            end
            FE_DELTA:
            begin
                delta_ok_reg <= !diff[OSQ_W];
                sq_x_reg     <= {dl, FRAC_BITS'(0)};
                sq_res_reg   <= '0;
                sq_bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                sq_cnt_reg   <= '0;
            end
            FE_SQRT:
            begin
                if (sq_x_reg >= trial)
                begin
                    sq_x_reg   <= sq_x_reg - trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            FE_ROOT:
            begin
                t_reg    <= t_sel[DIST_W-1:0];
                cand_reg <= (rad_reg != '0) && delta_ok_reg && !t_sel[ROOT_W-1]
                            && (t_sel != '0) && (t_sel[ROOT_W-1:DIST_W] == '0);
            end
            default: ;
        endcase
    end

endmodule

// ===== src/rsch_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rsch_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rsch_pkg::rsch_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output rsch_pkg::rsch_item_t pop_item,
    output logic                 valid
);
    import rsch_pkg::*;

    rsch_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== src/rsch_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_back
// Keep the nearest hit of a ray, derive its normal and emit the result.
// ----------------------------------------------------------------------------
module rsch_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [rsch_pkg::DIST_W-1:0] far_limit,
    input  logic                   q_valid,
    input  rsch_pkg::rsch_item_t   q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rsch_pkg::rsch_result_t out_result
);
    import rsch_pkg::*;

    be_state_t               state_reg, state_next;
    rsch_item_t              item_reg;
    logic                    open_reg;
    logic [IDX_W-1:0]        cnt_reg, cur_idx_reg;
    logic [DIST_W-1:0]       best_dist_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic signed [NRM_W-1:0] best_nrm_reg [3];
    logic                    found_reg;

    logic [1:0]              comp_reg;
    logic [NPROD_W-1:0]      prod_reg;
    logic                    psgn_reg;
    logic signed [PT_W-1:0]  pt_reg;
    logic                    pneg_reg, sat_reg, pbit_reg;
    logic [RAD_W-1:0]        rem_reg;
    logic [Q_W-1:0]          q_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;

    logic                    out_valid_reg;
    rsch_result_t            out_reg;

    logic signed [OFS_W-1:0]     ofs_sel;
    logic signed [DIR_W-1:0]     dir_sel;
    logic [DIR_W-1:0]            dmag;
    logic signed [NPROD_W:0]     sprod;
    logic [PT_W-1:0]             pmag;
    logic [RAD_W:0]              shl, sub;
    logic                        sub_ok;
    logic [Q_W-1:0]              nmag;
    logic signed [NRM_W-1:0]     nval;
    logic                        win, slot_free;

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin ofs_sel = item_reg.ofs_x; dir_sel = item_reg.dir_x; end
            2'd1:    begin ofs_sel = item_reg.ofs_y; dir_sel = item_reg.dir_y; end
            2'd2:    begin ofs_sel = item_reg.ofs_z; dir_sel = item_reg.dir_z; end
            default: begin ofs_sel = item_reg.ofs_x; dir_sel = item_reg.dir_x; end
        endcase
    end

    assign dmag  = dir_sel[DIR_W-1] ? DIR_W'(-dir_sel) : DIR_W'(dir_sel);
    assign sprod = psgn_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign pmag  = pt_reg[PT_W-1] ? PT_W'(-pt_reg) : PT_W'(pt_reg);

    // one restoring divide step; the low bit of |p| enters first, then zeros
    assign shl    = {rem_reg, (div_cnt_reg == '0) ? pbit_reg : 1'b0};
    assign sub    = shl - {1'b0, item_reg.radius};
    assign sub_ok = (shl >= {1'b0, item_reg.radius});

    assign nmag = (sat_reg || (q_reg > NRM_ONE)) ? NRM_ONE : q_reg;
    assign nval = pneg_reg ? -$signed(NRM_W'(nmag)) : $signed(NRM_W'(nmag));

    assign win       = item_reg.cand && (item_reg.t < best_dist_reg);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE:  if (q_valid) state_next = BE_EVAL;
            BE_EVAL:
                if (win)                state_next = BE_MUL;
                else if (item_reg.last) state_next = BE_EMIT;
                else                    state_next = BE_IDLE;
            BE_MUL:   state_next = BE_POINT;
            BE_POINT: state_next = BE_SAT;
            BE_SAT:   state_next = BE_DIV;
            BE_DIV:   if (sat_reg || div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                          state_next = BE_NORM;
            BE_NORM:
                if (comp_reg != 2'd2)   state_next = BE_MUL;
                else if (item_reg.last) state_next = BE_EMIT;
                else                    state_next = BE_IDLE;
            BE_EMIT:  if (slot_free) state_next = BE_IDLE;
            default:  state_next = BE_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = (state_reg == BE_IDLE) && q_valid;
        out_valid  = out_valid_reg;
        out_result = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            open_reg      <= 1'b0;
            cnt_reg       <= '0;
            cur_idx_reg   <= '0;
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
                best_nrm_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // load a new result when the slot frees, else drop the taken one
            if ((state_reg == BE_EMIT) && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                BE_IDLE:
                    if (q_valid)
                    begin
                        open_reg <= 1'b1;
                        if (!open_reg)
                        begin
                            best_dist_reg <= far_limit;
                            best_idx_reg  <= '0;
                            found_reg     <= 1'b0;
                            for (int k = 0; k < 3; k++)
                                best_nrm_reg[k] <= '0;
                            cur_idx_reg   <= '0;
                            cnt_reg       <= IDX_W'(1);
                        end
                        else
                        begin
                            cur_idx_reg <= cnt_reg;
                            cnt_reg     <= cnt_reg + 1'b1;
                        end
                    end
                BE_EVAL:
                    if (win)
                    begin
                        best_dist_reg <= item_reg.t;
                        best_idx_reg  <= cur_idx_reg;
                        found_reg     <= 1'b1;
                        comp_reg      <= '0;
                    end
                BE_NORM:
                begin
                    best_nrm_reg[comp_reg] <= nval;
                    comp_reg <= comp_reg + 1'b1;
                end
                BE_EMIT:
                    if (slot_free)
                        open_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BE_IDLE:
                if (q_valid)
                    item_reg <= q_item;
            BE_MUL:
            begin
                prod_reg <= NPROD_W'(item_reg.t) * NPROD_W'(dmag);
                psgn_reg <= dir_sel[DIR_W-1];
            end
            BE_POINT:
                pt_reg <= PT_W'(ofs_sel) + PT_W'($signed(sprod[NPROD_W:FRAC_BITS]));
            BE_SAT:
            begin
                pneg_reg    <= pt_reg[PT_W-1];
                sat_reg     <= (PT_W+1)'(pmag) >= (PT_W+1)'({item_reg.radius, 1'b0});
                rem_reg     <= pmag[RAD_W:1];
                pbit_reg    <= pmag[0];
                q_reg       <= '0;
                div_cnt_reg <= '0;
            end
            BE_DIV:
            begin
                rem_reg     <= sub_ok ? sub[RAD_W-1:0] : shl[RAD_W-1:0];
                q_reg       <= {q_reg[Q_W-2:0], sub_ok};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            BE_EMIT:
                if (slot_free)
                    out_reg <= '{hit: found_reg, distance: best_dist_reg,
                                 sphere_index: best_idx_reg,
                                 normal_x: best_nrm_reg[0],
                                 normal_y: best_nrm_reg[1],
                                 normal_z: best_nrm_reg[2]};
            default: ;
        endcase
    end

endmodule
